// ===== sv/pdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg
// Types and constants shared by the pose dead-reckoning block.
// ----------------------------------------------------------------------------
package pdr_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

   localparam logic [15:0] TICK_RESET  = 16'd655;
   localparam logic [31:0] HEAD_SCALE  = 32'd683565276;   // 65536/(2*pi), Q16
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;  // 1/K, Q30
   localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;
   localparam logic signed [25:0] HALF_TURN    = 26'sd8388608;

   // arctan(2^-i) in 2^24-per-turn units
   localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
      22'd166669,  22'd83416,   22'd41718,  22'd20860,
      22'd10430,   22'd5215,    22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81
   };

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic        [15:0] heading;
   } rsp_type;

   typedef enum logic [1:0] {
      MSEL_HEAD,
      MSEL_X,
      MSEL_Y
   } mul_sel_type;

   typedef struct packed {
      logic              load_req;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              head_upd;
      logic              cordic_init;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              x_upd;
      logic              y_upd;
      logic              rsp_load;
   } cmd_type;

endpackage

// ===== sv/pdr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_datapath
// Pose registers, shared 32x32 multiplier, iterative CORDIC and result
// register, stepped by the controller's commands.
// ----------------------------------------------------------------------------
module pdr_datapath (
   input  logic             clock,
   input  logic             reset,
   input  pdr_pkg::cmd_type cmd,
   input  pdr_pkg::req_type req_data,
   input  logic             csr_wr,
   input  logic [15:0]      csr_data,
   output pdr_pkg::rsp_type rsp_data
);
   import pdr_pkg::*;

   logic [15:0]        tick_ff;
   logic signed [31:0] x_acc_ff, x_acc_in;
   logic signed [31:0] y_acc_ff, y_acc_in;
   logic [15:0]        heading_ff, heading_in;

   logic [31:0]        p_mag_ff, d_mag_ff;
   logic               p_neg_ff, d_neg_ff;
   logic [63:0]        prod_ff;

   logic signed [33:0] cx_ff, cy_ff;
   logic signed [25:0] ang_ff;
   logic               flip_ff;

   rsp_type            rsp_ff;

   // request operands
   logic signed [32:0] tick_ext, rate_ext, spd_ext, p_s, d_s;
   assign tick_ext = $signed({17'b0, tick_ff});
   assign rate_ext = 33'(req_data.turn_rate);
   assign spd_ext  = 33'(req_data.speed);
   assign p_s      = rate_ext * tick_ext;
   assign d_s      = spd_ext * tick_ext;

   // cos / sin magnitudes
   logic signed [33:0] cos_s, sin_s, cos_a, sin_a;
   logic               cos_neg, sin_neg;
   assign cos_s   = flip_ff ? -cx_ff : cx_ff;
   assign sin_s   = flip_ff ? -cy_ff : cy_ff;
   assign cos_neg = cos_s[33];
   assign sin_neg = sin_s[33];
   assign cos_a   = cos_neg ? -cos_s : cos_s;
   assign sin_a   = sin_neg ? -sin_s : sin_s;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   always_comb begin
      mul_a = d_mag_ff;
      mul_b = cos_a[31:0];
      case (cmd.mul_sel)
         MSEL_HEAD: begin
            mul_a = p_mag_ff;
            mul_b = HEAD_SCALE;
         end
         MSEL_X: mul_b = cos_a[31:0];
         MSEL_Y: mul_b = sin_a[31:0];
         default: mul_b = cos_a[31:0];
      endcase
   end

   // heading step, round half away from zero at bit 44
   logic [63:0] rnd_h;
   logic [15:0] dh;
   assign rnd_h = prod_ff + (64'd1 << 43);
   assign dh    = p_neg_ff ? -rnd_h[59:44] : rnd_h[59:44];
   assign heading_in = heading_ff + dh;

   // position step, round half away from zero at bit 42
   logic [63:0]        rnd_p;
   logic signed [32:0] step_mag, step_x, step_y, sum_x, sum_y;
   assign rnd_p    = prod_ff + (64'd1 << 41);
   assign step_mag = $signed({11'b0, rnd_p[63:42]});
   assign step_x   = (d_neg_ff ^ cos_neg) ? -step_mag : step_mag;
   assign step_y   = (d_neg_ff ^ sin_neg) ? -step_mag : step_mag;
   assign sum_x    = 33'(x_acc_ff) + step_x;
   assign sum_y    = 33'(y_acc_ff) + step_y;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] == v[31]) return v[31:0];
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   assign x_acc_in = sat32(sum_x);
   assign y_acc_in = sat32(sum_y);

   logic signed [33:0] sh_x, sh_y;
   logic signed [25:0] atan_s;
   assign sh_x   = cx_ff >>> cmd.iter;
   assign sh_y   = cy_ff >>> cmd.iter;
   assign atan_s = $signed({4'b0, ATAN_TAB[cmd.iter]});

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= TICK_RESET;
         x_acc_ff   <= '0;
         y_acc_ff   <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_wr) tick_ff <= csr_data;
         if (cmd.head_upd) heading_ff <= heading_in;
         if (cmd.x_upd) x_acc_ff <= x_acc_in;
         if (cmd.y_upd) y_acc_ff <= y_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         p_neg_ff <= p_s[32];
         p_mag_ff <= p_s[32] ? 32'(-p_s) : p_s[31:0];
         d_neg_ff <= d_s[32];
         d_mag_ff <= d_s[32] ? 32'(-d_s) : d_s[31:0];
      end
      if (cmd.mul_en) prod_ff <= mul_a * mul_b;
      if (cmd.cordic_init) begin
         cx_ff <= CORDIC_X0;
         cy_ff <= '0;
         // heading_ff already holds the new heading here
         if ($signed({heading_ff, 8'b0}) > $signed(QUARTER_TURN[24:0])) begin
            ang_ff  <= 26'($signed({heading_ff, 8'b0})) - HALF_TURN;
            flip_ff <= 1'b1;
         end else if ($signed({heading_ff, 8'b0}) < -$signed(QUARTER_TURN[24:0])) begin
            ang_ff  <= 26'($signed({heading_ff, 8'b0})) + HALF_TURN;
            flip_ff <= 1'b1;
         end else begin
            ang_ff  <= 26'($signed({heading_ff, 8'b0}));
            flip_ff <= 1'b0;
         end
      end
      if (cmd.cordic_step) begin
         if (!ang_ff[25]) begin
            cx_ff  <= cx_ff - sh_y;
            cy_ff  <= cy_ff + sh_x;
            ang_ff <= ang_ff - atan_s;
         end else begin
            cx_ff  <= cx_ff + sh_y;
            cy_ff  <= cy_ff - sh_x;
            ang_ff <= ang_ff + atan_s;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.pos_x   <= x_acc_ff;
         rsp_ff.pos_y   <= y_acc_ff;
         rsp_ff.heading <= heading_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/pdr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_ctrl
// Sequencer for one request: heading multiply, heading update, CORDIC
// iterations, x and y multiply/accumulate, result hand-off.
// ----------------------------------------------------------------------------
module pdr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pdr_pkg::cmd_type cmd
);
   import pdr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HMUL,
      S_HADD,
      S_CINIT,
      S_CITER,
      S_XMUL,
      S_XADD,
      S_YMUL,
      S_YADD,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.mul_sel  = MSEL_HEAD;
      cmd.iter     = iter_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HMUL;
            end
         end
         S_HMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_HEAD;
            state_in    = S_HADD;
         end
         S_HADD: begin
            cmd.head_upd = 1'b1;
            state_in     = S_CINIT;
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            iter_in         = '0;
            state_in        = S_CITER;
         end
         S_CITER: begin
            cmd.cordic_step = 1'b1;
            iter_in         = ITER_W'(iter_ff + 1'b1);
            if (iter_ff == CORDIC_LAST) state_in = S_XMUL;
         end
         S_XMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_X;
            state_in    = S_XADD;
         end
         S_XADD: begin
            cmd.x_upd = 1'b1;
            state_in  = S_YMUL;
         end
         S_YMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_Y;
            state_in    = S_YADD;
         end
         S_YADD: begin
            cmd.y_upd = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_HMUL)
      else $error("accepted request did not start the sequence");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending result");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result loaded without valid");

   a_cordic_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CITER && iter_ff == CORDIC_LAST |=> state_ff == S_XMUL)
      else $error("CORDIC did not end after the last iteration");

endmodule

// ===== sv/pose_dead_reckoning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_dead_reckoning
// A new request is taken only in idle: req_stall stays high through the
// 16-step CORDIC loop, three passes through the one shared 32x32
// multiplier and the result hand-off, which rsp_stall can hold.
// Reset (synchronous): pose cleared to zero, tick period back to 655.
// Dead-reckoning odometry: heading, then x/y, from speed and turn rate.
// ----------------------------------------------------------------------------
module pose_dead_reckoning (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pdr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pdr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import pdr_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   pdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pdr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_wr   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule
